// ----- rtl/core/n2a_pkg.sv -----
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, constants and color math for the NV21 to ARGB converter.
// ----------------------------------------------------------------------------
package n2a_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 13;
    localparam int DEST_W = 24;

    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int COL_W  = X_W - 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = X_W + 1;
    localparam int HGT_W  = ROW_W + 1;

    localparam int MUL_A_W = (X_W > ROW_W) ? X_W : ROW_W;
    localparam int MUL_B_W = (WID_W > HGT_W) ? WID_W : HGT_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_ROTATE = 2'd2
    } cfg_index_t;

    // 7-bit fixed-point conversion factors.
    localparam logic signed [17:0] K_RV = 18'sd176;
    localparam logic signed [17:0] K_GV = 18'sd89;
    localparam logic signed [17:0] K_GU = 18'sd43;
    localparam logic signed [17:0] K_BU = 18'sd222;
    localparam logic signed [17:0] C_MID = 18'sd128;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic [COL_W:0]   pairs;
        logic             rotate;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] y_even;
        logic [PIX_W-1:0] y_odd;
        logic [PIX_W-1:0] v_even;
        logic [PIX_W-1:0] u_even;
        logic [PIX_W-1:0] v_odd;
        logic [PIX_W-1:0] u_odd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } pair_job_t;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        rgb_t              even;
        rgb_t              odd;
        logic [DEST_W-1:0] dest_even;
        logic [DEST_W-1:0] dest_odd;
        logic              last;
    } out_item_t;

    // Floor divide by 128 and clamp to 0..255.
    function automatic logic [PIX_W-1:0] clip8(input logic signed [17:0] t);
        logic signed [10:0] q;
        q = t[17:7];
        if (q < 0)
            clip8 = '0;
        else if (q > 11'sd255)
            clip8 = '1;
        else
            clip8 = q[PIX_W-1:0];
    endfunction

    function automatic rgb_t ycc_to_rgb(input logic [PIX_W-1:0] y,
                                        input logic [PIX_W-1:0] v,
                                        input logic [PIX_W-1:0] u);
        logic signed [17:0] yy;
        logic signed [17:0] dv;
        logic signed [17:0] du;
        rgb_t               c;
        yy = $signed({3'b000, y, 7'b0000000});
        dv = $signed({10'd0, v}) - C_MID;
        du = $signed({10'd0, u}) - C_MID;
        c.r = clip8(yy + K_RV * dv);
        c.g = clip8(yy - K_GV * dv - K_GU * du);
        c.b = clip8(yy + K_BU * du);
        ycc_to_rgb = c;
    endfunction

endpackage

// ----- rtl/core/n2a_pixel_if.sv -----
// ----------------------------------------------------------------------------
// n2a_pixel_if
// Input channel: one NV21 pixel pair per request.
// ----------------------------------------------------------------------------
interface n2a_pixel_if import n2a_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma_even;
    logic [PIX_W-1:0] luma_odd;
    logic [PIX_W-1:0] chroma_v;
    logic [PIX_W-1:0] chroma_u;

    modport source (output valid, luma_even, luma_odd, chroma_v, chroma_u, input ready);
    modport sink (input valid, luma_even, luma_odd, chroma_v, chroma_u, output ready);
endinterface

// ----- rtl/core/n2a_result_if.sv -----
// ----------------------------------------------------------------------------
// n2a_result_if
// Output channel: two RGB pixels with their destination indices per request.
// ----------------------------------------------------------------------------
interface n2a_result_if import n2a_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red_even;
    logic [PIX_W-1:0]  green_even;
    logic [PIX_W-1:0]  blue_even;
    logic [PIX_W-1:0]  red_odd;
    logic [PIX_W-1:0]  green_odd;
    logic [PIX_W-1:0]  blue_odd;
    logic [DEST_W-1:0] dest_even;
    logic [DEST_W-1:0] dest_odd;
    logic              last_of_run;

    modport source (output valid, red_even, green_even, blue_even, red_odd, green_odd,
                    blue_odd, dest_even, dest_odd, last_of_run, input ready);
    modport sink (input valid, red_even, green_even, blue_even, red_odd, green_odd,
                  blue_odd, dest_even, dest_odd, last_of_run, output ready);
endinterface

// ----- rtl/core/n2a_cfg_if.sv -----
// ----------------------------------------------------------------------------
// n2a_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface n2a_cfg_if import n2a_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/nv21_to_argb_converter.sv -----
// ----------------------------------------------------------------------------
// nv21_to_argb_converter
// A pair's result passes the job queue and then the output register after the
// request that releases it (the next pair of its row, or its own request at
// a row's end). Throughput: one pair per cycle while the output is not stalled;
// intake pauses after a row's last pair, as the single converter has two queued.
// Reset: rst_n clears the stream position and sets 640x480, no rotation.
// ----------------------------------------------------------------------------
module nv21_to_argb_converter import n2a_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    n2a_pixel_if.sink     pixel,
    n2a_result_if.source  result,
    n2a_cfg_if.sink       cfg
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             rotate_reg, rotate_next;

    geom_t            geom;
    logic [DIM_W-1:0] w_even;
    pair_job_t        job;
    logic             job_valid;
    logic             job_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        rotate_next = rotate_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WIDTH:  width_next  = cfg.data;
                CFG_HEIGHT: height_next = cfg.data;
                CFG_ROTATE: rotate_next = cfg.data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            rotate_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            rotate_reg <= rotate_next;
        end
    end

    // Width is rounded down to even and held to 2..MAX_WIDTH; height to 1..MAX_HEIGHT.
    always_comb
    begin
        w_even = {width_reg[DIM_W-1:1], 1'b0};
        if (w_even < DIM_W'(2))
            geom.width = WID_W'(2);
        else if ({1'b0, w_even} > (DIM_W+1)'(MAX_WIDTH))
            geom.width = WID_W'(MAX_WIDTH & ~1);
        else
            geom.width = WID_W'(w_even);

        if (height_reg == '0)
            geom.height = HGT_W'(1);
        else if ({1'b0, height_reg} > (DIM_W+1)'(MAX_HEIGHT))
            geom.height = HGT_W'(MAX_HEIGHT);
        else
            geom.height = HGT_W'(height_reg);

        geom.pairs  = geom.width[WID_W-1:1];
        geom.rotate = rotate_reg;
    end

    n2a_pair_tracker u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .geom      (geom),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    n2a_pixel_convert u_convert
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .geom      (geom),
        .result    (result)
    );

endmodule

// ----- rtl/core/n2a_pair_tracker.sv -----
// ----------------------------------------------------------------------------
// n2a_pair_tracker
// Tracks the stream position, holds one pair back and queues up to two
// pair jobs for the color converter.
// ----------------------------------------------------------------------------
module n2a_pair_tracker import n2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    n2a_pixel_if.sink         pixel,
    input  geom_t             geom,
    output pair_job_t         job,
    output logic              job_valid,
    input  logic              job_pop
);

    logic [PIX_W-1:0] pend_ye_reg, pend_ye_next;
    logic [PIX_W-1:0] pend_yo_reg, pend_yo_next;
    logic [PIX_W-1:0] pend_v_reg, pend_v_next;
    logic [PIX_W-1:0] pend_u_reg, pend_u_next;
    logic [PIX_W-1:0] prev_v_reg, prev_v_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       cnt_reg, cnt_next;
    pair_job_t        slot_a_reg, slot_a_next;
    pair_job_t        slot_b_reg, slot_b_next;

    logic             accept;
    logic [ROW_W-1:0] row_eff;
    logic [COL_W:0]   col_inc;
    logic [HGT_W-1:0] row_inc;
    logic             is_last;
    logic [PIX_W-1:0] pv;
    logic [PIX_W:0]   sum_prev_v;
    logic [PIX_W:0]   sum_next_u;
    logic [PIX_W:0]   sum_new_v;
    pair_job_t        job_old;
    pair_job_t        job_new;

    assign pixel.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && job_pop);
    assign accept      = pixel.valid && pixel.ready;
    assign job         = slot_a_reg;
    assign job_valid   = (cnt_reg != 2'd0);

    always_comb
    begin
        // A row left past the height by a configuration change restarts at 0.
        row_eff    = ({1'b0, row_reg} >= geom.height) ? '0 : row_reg;
        col_inc    = {1'b0, col_reg} + 1'b1;
        row_inc    = {1'b0, row_eff} + 1'b1;
        is_last    = (col_inc >= geom.pairs);
        pv         = pend_valid_reg ? pend_v_reg : pixel.chroma_v;
        sum_prev_v = {1'b0, prev_v_reg} + {1'b0, pend_v_reg};
        sum_next_u = {1'b0, pend_u_reg} + {1'b0, pixel.chroma_u};
        sum_new_v  = {1'b0, pv} + {1'b0, pixel.chroma_v};

        job_old.y_even = pend_ye_reg;
        job_old.y_odd  = pend_yo_reg;
        job_old.v_even = sum_prev_v[PIX_W:1];
        job_old.u_even = pend_u_reg;
        job_old.v_odd  = pend_v_reg;
        job_old.u_odd  = sum_next_u[PIX_W:1];
        job_old.col    = col_reg - 1'b1;
        job_old.row    = row_eff;
        job_old.last   = !is_last;

        // The last pair of a row has no next U: its own U is repeated.
        job_new.y_even = pixel.luma_even;
        job_new.y_odd  = pixel.luma_odd;
        job_new.v_even = sum_new_v[PIX_W:1];
        job_new.u_even = pixel.chroma_u;
        job_new.v_odd  = pixel.chroma_v;
        job_new.u_odd  = pixel.chroma_u;
        job_new.col    = col_reg;
        job_new.row    = row_eff;
        job_new.last   = 1'b1;
    end

    always_comb
    begin
        pend_ye_next    = pend_ye_reg;
        pend_yo_next    = pend_yo_reg;
        pend_v_next     = pend_v_reg;
        pend_u_next     = pend_u_reg;
        prev_v_next     = prev_v_reg;
        pend_valid_next = pend_valid_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        slot_a_next     = slot_a_reg;
        slot_b_next     = slot_b_reg;

        if (job_pop)
        begin
            slot_a_next = slot_b_reg;
            cnt_next    = cnt_reg - 1'b1;
        end

        if (accept)
        begin
            if (pend_valid_reg && is_last)
            begin
                slot_a_next = job_old;
                slot_b_next = job_new;
                cnt_next    = 2'd2;
            end
            else if (pend_valid_reg)
            begin
                slot_a_next = job_old;
                cnt_next    = 2'd1;
            end
            else if (is_last)
            begin
                slot_a_next = job_new;
                cnt_next    = 2'd1;
            end
            else
            begin
                cnt_next = 2'd0;
            end

            if (is_last)
            begin
                pend_valid_next = 1'b0;
                col_next        = '0;
                row_next        = (row_inc >= geom.height) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                prev_v_next     = pv;
                pend_ye_next    = pixel.luma_even;
                pend_yo_next    = pixel.luma_odd;
                pend_v_next     = pixel.chroma_v;
                pend_u_next     = pixel.chroma_u;
                pend_valid_next = 1'b1;
                col_next        = col_inc[COL_W-1:0];
                row_next        = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ye_reg <= pend_ye_next;
        pend_yo_reg <= pend_yo_next;
        pend_v_reg  <= pend_v_next;
        pend_u_reg  <= pend_u_next;
        prev_v_reg  <= prev_v_next;
        slot_a_reg  <= slot_a_next;
        slot_b_reg  <= slot_b_next;
    end

endmodule

// ----- rtl/core/n2a_pixel_convert.sv -----
// ----------------------------------------------------------------------------
// n2a_pixel_convert
// Converts one pair job to two RGB pixels and their destination indices
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module n2a_pixel_convert import n2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pair_job_t         job,
    input  logic              job_valid,
    output logic              job_pop,
    input  geom_t             geom,
    n2a_result_if.source      result
);

    logic             out_valid_reg, out_valid_next;
    out_item_t        res_reg, res_next;

    logic [X_W-1:0]     x;
    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  offs;
    logic [PROD_W-1:0]  dest_e;
    logic [PROD_W-1:0]  dest_o;
    logic [HGT_W-1:0]   flip_row;

    assign job_pop = job_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        x        = {job.col, 1'b0};
        // The row was below the height when the job was queued, so this wraps only if the height has shrunk since.
        flip_row = geom.height - 1'b1 - HGT_W'(job.row);
        op_a     = geom.rotate ? MUL_A_W'(x) : MUL_A_W'(job.row);
        op_b     = geom.rotate ? MUL_B_W'(geom.height) : MUL_B_W'(geom.width);
        prod     = PROD_W'(op_a) * PROD_W'(op_b);
        offs     = geom.rotate ? PROD_W'(flip_row) : PROD_W'(x);
        dest_e   = prod + offs;
        dest_o   = dest_e + (geom.rotate ? PROD_W'(geom.height) : PROD_W'(1));

        res_next           = res_reg;
        out_valid_next     = out_valid_reg;
        if (job_pop)
        begin
            res_next.even      = ycc_to_rgb(job.y_even, job.v_even, job.u_even);
            res_next.odd       = ycc_to_rgb(job.y_odd, job.v_odd, job.u_odd);
            res_next.dest_even = dest_e[DEST_W-1:0];
            res_next.dest_odd  = dest_o[DEST_W-1:0];
            res_next.last      = job.last;
            out_valid_next     = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.red_even    = res_reg.even.r;
    assign result.green_even  = res_reg.even.g;
    assign result.blue_even   = res_reg.even.b;
    assign result.red_odd     = res_reg.odd.r;
    assign result.green_odd   = res_reg.odd.g;
    assign result.blue_odd    = res_reg.odd.b;
    assign result.dest_even   = res_reg.dest_even;
    assign result.dest_odd    = res_reg.dest_odd;
    assign result.last_of_run = res_reg.last;

endmodule
